// ----- hdl/hret_pkg.sv -----
// Shared widths, constants and controller/datapath handshake types for the
// histogram rebinning block. Depends on nothing; every other file uses it.
package hret_pkg;

   // Field widths of the input word, the result word and the register.
   localparam int CONTENT_W = 32;
   localparam int ERROR_W   = 16;
   localparam int EDGE_W    = 32;
   localparam int SUM_W     = 38;
   localparam int ROOT_W    = 19;
   localparam int CFG_W     = 7;

   // Group size after reset.
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;   // latch the accepted input word
      logic accum;  // add the latched bin into the running group
      logic shift;  // trim, emit the held bin and hold the new coarse bin
      logic flush;  // emit the held bin as last and clear the stream
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic group_done;  // the latched bin completes a group
      logic last;        // the latched bin ends the histogram
      logic held_valid;  // a coarse bin is held back
      logic out_free;    // the result register can take a word this cycle
      logic root_done;   // the square root unit has finished
   } status_type;

endpackage

// ----- hdl/hret_if.sv -----
// Channel interfaces for the histogram rebinning block: fine bins in,
// coarse bins out and the group size write port. Depends on hret_pkg.

interface hret_req_if;
   logic                            valid;
   logic                            ready;
   logic [hret_pkg::CONTENT_W-1:0]  fine_content;
   logic [hret_pkg::ERROR_W-1:0]    fine_error;
   logic [hret_pkg::EDGE_W-1:0]     fine_low_edge;
   logic [hret_pkg::EDGE_W-1:0]     fine_up_edge;
   logic                            fine_last;

   modport source (output valid, fine_content, fine_error, fine_low_edge, fine_up_edge,
                   fine_last, input ready);
   modport sink (input valid, fine_content, fine_error, fine_low_edge, fine_up_edge,
                 fine_last, output ready);
endinterface

interface hret_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hret_pkg::SUM_W-1:0]  coarse_content;
   logic [hret_pkg::ROOT_W-1:0] coarse_error;
   logic [hret_pkg::EDGE_W-1:0] coarse_low_edge;
   logic [hret_pkg::EDGE_W-1:0] coarse_up_edge;
   logic                        coarse_last;

   modport source (output valid, coarse_content, coarse_error, coarse_low_edge,
                   coarse_up_edge, coarse_last, input ready);
   modport sink (input valid, coarse_content, coarse_error, coarse_low_edge,
                 coarse_up_edge, coarse_last, output ready);
endinterface

interface hret_csr_if;
   logic                       valid;
   logic                       ready;
   logic [hret_pkg::CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- hdl/hret_sqrt.sv -----
// Bit-serial floor square root, one result bit per cycle.
// Depends on hret_pkg for the radicand and root widths.
module hret_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hret_pkg::SUM_W-1:0]    radicand,
   output logic                          done,
   output logic [hret_pkg::ROOT_W-1:0]   root
);

   localparam int RW    = hret_pkg::ROOT_W + 2;
   localparam int STEPW = $clog2(hret_pkg::ROOT_W);
   localparam logic [STEPW-1:0] LAST_STEP = STEPW'(hret_pkg::ROOT_W - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEPW-1:0]            step_ff, step_in;
   logic [hret_pkg::SUM_W-1:0]  rad_ff, rad_in;
   logic [RW-1:0]               rem_ff, rem_in;
   logic [hret_pkg::ROOT_W-1:0] root_ff, root_in;

   logic [RW-1:0] rem_shift;
   logic [RW-1:0] trial;

   // One digit step: bring in two radicand bits and try the next root bit.
   always_comb begin
      rem_shift = {rem_ff[RW-3:0], rad_ff[hret_pkg::SUM_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[hret_pkg::SUM_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[hret_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[hret_pkg::ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff + STEPW'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags reset; the working values need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- hdl/hret_datapath.sv -----
// Datapath of the histogram rebinning block: input latch, group sums, held
// coarse bin, edge trimming and the result register. Depends on hret_pkg
// and hret_sqrt.
module hret_datapath #(
   parameter int MAX_GROUP = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hret_pkg::cmd_type                cmd,
   output hret_pkg::status_type             status,
   input  logic                             csr_valid,
   input  logic [hret_pkg::CFG_W-1:0]       csr_data,
   input  logic [hret_pkg::CONTENT_W-1:0]   fine_content,
   input  logic [hret_pkg::ERROR_W-1:0]     fine_error,
   input  logic [hret_pkg::EDGE_W-1:0]      fine_low_edge,
   input  logic [hret_pkg::EDGE_W-1:0]      fine_up_edge,
   input  logic                             fine_last,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [hret_pkg::SUM_W-1:0]       coarse_content,
   output logic [hret_pkg::ROOT_W-1:0]      coarse_error,
   output logic [hret_pkg::EDGE_W-1:0]      coarse_low_edge,
   output logic [hret_pkg::EDGE_W-1:0]      coarse_up_edge,
   output logic                             coarse_last
);

   localparam int CW   = $clog2(MAX_GROUP + 1);
   localparam int CMPW = (CW > hret_pkg::CFG_W) ? CW : hret_pkg::CFG_W;
   localparam int SW   = hret_pkg::SUM_W;

   typedef enum logic [1:0] {
      TRIM_SEEK_FIRST = 2'd0,
      TRIM_SEEK_ZERO  = 2'd1,
      TRIM_DONE       = 2'd2
   } trim_phase_type;

   // Group size register.
   logic [hret_pkg::CFG_W-1:0] size_ff, size_in;

   // Latched input word.
   logic [hret_pkg::CONTENT_W-1:0] in_content_ff, in_content_in;
   logic [hret_pkg::ERROR_W-1:0]   in_error_ff, in_error_in;
   logic [hret_pkg::EDGE_W-1:0]    in_low_ff, in_low_in;
   logic [hret_pkg::EDGE_W-1:0]    in_up_ff, in_up_in;
   logic                           in_last_ff, in_last_in;

   // Running group.
   logic [CW-1:0]               count_ff, count_in;
   logic [SW-1:0]               csum_ff, csum_in;
   logic [SW-1:0]               esum_ff, esum_in;
   logic [hret_pkg::EDGE_W-1:0] start_edge_ff, start_edge_in;

   // Completed group waiting for its root.
   logic [SW-1:0]               new_content_ff, new_content_in;
   logic [hret_pkg::EDGE_W-1:0] new_low_ff, new_low_in;
   logic [hret_pkg::EDGE_W-1:0] new_up_ff, new_up_in;

   // Held coarse bin and trim state.
   logic                         held_valid_ff, held_valid_in;
   logic [SW-1:0]                held_content_ff, held_content_in;
   logic [hret_pkg::ROOT_W-1:0]  held_error_ff, held_error_in;
   logic [hret_pkg::EDGE_W-1:0]  held_low_ff, held_low_in;
   logic [hret_pkg::EDGE_W-1:0]  held_up_ff, held_up_in;
   trim_phase_type               phase_ff, phase_in;

   // Result register.
   logic                         out_valid_ff, out_valid_in;
   logic [SW-1:0]                out_content_ff, out_content_in;
   logic [hret_pkg::ROOT_W-1:0]  out_error_ff, out_error_in;
   logic [hret_pkg::EDGE_W-1:0]  out_low_ff, out_low_in;
   logic [hret_pkg::EDGE_W-1:0]  out_up_ff, out_up_in;
   logic                         out_last_ff, out_last_in;

   logic [CMPW-1:0]                  size_ext;
   logic [CMPW-1:0]                  size_eff;
   logic [CMPW-1:0]                  count_inc;
   logic                             group_done;
   logic [2*hret_pkg::ERROR_W-1:0]   err_sq;
   logic [SW:0]                      csum_add;
   logic [SW:0]                      esum_add;
   logic [SW-1:0]                    csum_sat;
   logic [SW-1:0]                    esum_sat;
   logic                             root_start;
   logic                             root_done;
   logic [hret_pkg::ROOT_W-1:0]      root_val;
   logic                             out_free;
   logic                             emit;
   logic                             zero_held;

   // Effective group size: zero counts as one, large values clamp.
   always_comb begin
      size_ext = CMPW'(size_ff);
      if (size_ff == '0) begin
         size_eff = CMPW'(1);
      end else if (size_ext > CMPW'(MAX_GROUP)) begin
         size_eff = CMPW'(MAX_GROUP);
      end else begin
         size_eff = size_ext;
      end
      count_inc  = CMPW'(count_ff) + CMPW'(1);
      group_done = (count_inc >= size_eff);
   end

   // Saturating sums of content and squared error.
   always_comb begin
      err_sq   = in_error_ff * in_error_ff;
      csum_add = {1'b0, csum_ff} + (SW + 1)'(in_content_ff);
      esum_add = {1'b0, esum_ff} + (SW + 1)'(err_sq);
      csum_sat = csum_add[SW] ? {SW{1'b1}} : csum_add[SW-1:0];
      esum_sat = esum_add[SW] ? {SW{1'b1}} : esum_add[SW-1:0];
   end

   assign root_start = cmd.accum & group_done;
   assign out_free   = ~out_valid_ff | rsp_ready;
   assign emit       = (cmd.shift | cmd.flush) & held_valid_ff;
   // The held bin just before the first zero bin after trimming starts is zeroed.
   assign zero_held  = (phase_ff == TRIM_SEEK_ZERO) && (new_content_ff == '0);

   hret_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (esum_sat),
      .done     (root_done),
      .root     (root_val)
   );

   // Next-state logic for all datapath registers.
   always_comb begin
      size_in         = csr_valid ? csr_data : size_ff;
      in_content_in   = in_content_ff;
      in_error_in     = in_error_ff;
      in_low_in       = in_low_ff;
      in_up_in        = in_up_ff;
      in_last_in      = in_last_ff;
      count_in        = count_ff;
      csum_in         = csum_ff;
      esum_in         = esum_ff;
      start_edge_in   = start_edge_ff;
      new_content_in  = new_content_ff;
      new_low_in      = new_low_ff;
      new_up_in       = new_up_ff;
      held_valid_in   = held_valid_ff;
      held_content_in = held_content_ff;
      held_error_in   = held_error_ff;
      held_low_in     = held_low_ff;
      held_up_in      = held_up_ff;
      phase_in        = phase_ff;
      out_valid_in    = out_valid_ff & ~rsp_ready;
      out_content_in  = out_content_ff;
      out_error_in    = out_error_ff;
      out_low_in      = out_low_ff;
      out_up_in       = out_up_ff;
      out_last_in     = out_last_ff;

      // Latch the accepted word.
      if (cmd.take) begin
         in_content_in = fine_content;
         in_error_in   = fine_error;
         in_low_in     = fine_low_edge;
         in_up_in      = fine_up_edge;
         in_last_in    = fine_last;
      end

      // Add the bin to the group; a finished group moves to the new-bin slot.
      if (cmd.accum) begin
         if (group_done) begin
            count_in       = '0;
            csum_in        = '0;
            esum_in        = '0;
            new_content_in = csum_sat;
            new_low_in     = (count_ff == '0) ? in_low_ff : start_edge_ff;
            new_up_in      = in_up_ff;
         end else begin
            count_in = CW'(count_inc);
            csum_in  = csum_sat;
            esum_in  = esum_sat;
            if (count_ff == '0) begin
               start_edge_in = in_low_ff;
            end
         end
      end

      // Emit the held bin, zeroed if it precedes the first zero bin.
      if (emit) begin
         out_valid_in   = 1'b1;
         out_content_in = (cmd.shift && zero_held) ? '0 : held_content_ff;
         out_error_in   = held_error_ff;
         out_low_in     = held_low_ff;
         out_up_in      = held_up_ff;
         out_last_in    = cmd.flush;
      end

      // Hold the new coarse bin and step the trim phase.
      if (cmd.shift) begin
         held_valid_in   = 1'b1;
         held_content_in = new_content_ff;
         held_error_in   = root_val;
         held_low_in     = new_low_ff;
         held_up_in      = new_up_ff;
         case (phase_ff)
            TRIM_SEEK_FIRST: begin
               if (new_content_ff != '0) begin
                  held_content_in = '0;
                  phase_in        = TRIM_SEEK_ZERO;
               end
            end
            TRIM_SEEK_ZERO: begin
               if (new_content_ff == '0) begin
                  phase_in = TRIM_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // End of histogram: the stream state goes back to its reset values.
      if (cmd.flush) begin
         count_in      = '0;
         csum_in       = '0;
         esum_in       = '0;
         start_edge_in = '0;
         held_valid_in = 1'b0;
         phase_in      = TRIM_SEEK_FIRST;
      end
   end

   // Control state resets; payload registers load freely.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= hret_pkg::CFG_RESET;
         count_ff      <= '0;
         csum_ff       <= '0;
         esum_ff       <= '0;
         start_edge_ff <= '0;
         held_valid_ff <= 1'b0;
         phase_ff      <= TRIM_SEEK_FIRST;
         out_valid_ff  <= 1'b0;
      end else begin
         size_ff       <= size_in;
         count_ff      <= count_in;
         csum_ff       <= csum_in;
         esum_ff       <= esum_in;
         start_edge_ff <= start_edge_in;
         held_valid_ff <= held_valid_in;
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
      end
      in_content_ff   <= in_content_in;
      in_error_ff     <= in_error_in;
      in_low_ff       <= in_low_in;
      in_up_ff        <= in_up_in;
      in_last_ff      <= in_last_in;
      new_content_ff  <= new_content_in;
      new_low_ff      <= new_low_in;
      new_up_ff       <= new_up_in;
      held_content_ff <= held_content_in;
      held_error_ff   <= held_error_in;
      held_low_ff     <= held_low_in;
      held_up_ff      <= held_up_in;
      out_content_ff  <= out_content_in;
      out_error_ff    <= out_error_in;
      out_low_ff      <= out_low_in;
      out_up_ff       <= out_up_in;
      out_last_ff     <= out_last_in;
   end

   // Status to the controller.
   always_comb begin
      status.group_done = group_done;
      status.last       = in_last_ff;
      status.held_valid = held_valid_ff;
      status.out_free   = out_free;
      status.root_done  = root_done;
   end

   assign rsp_valid       = out_valid_ff;
   assign coarse_content  = out_content_ff;
   assign coarse_error    = out_error_ff;
   assign coarse_low_edge = out_low_ff;
   assign coarse_up_edge  = out_up_ff;
   assign coarse_last     = out_last_ff;

`ifndef SYNTHESIS
   // A pending result word is never overwritten by a new one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result word overwritten before it was taken");

   // A flush leaves the stream in its reset state.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (!held_valid_ff && count_ff == '0 && phase_ff == TRIM_SEEK_FIRST))
      else $error("stream state not cleared after flush");

   // The group count never runs past the largest group.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (CMPW'(count_ff) < CMPW'(MAX_GROUP)))
      else $error("group count out of range");

   // The square root is not started again right after it finishes.
   a_shift_after_root: assert property (@(posedge clock) disable iff (reset)
      root_done |=> !root_start)
      else $error("square root restarted right after finishing");
`endif

endmodule

// ----- hdl/hret_ctrl.sv -----
// Controller of the histogram rebinning block: sequences accept,
// accumulate, square root, emit and flush. Depends on hret_pkg.
module hret_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hret_pkg::status_type  status,
   output hret_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ACCUM = 5'b00010,
      ST_ROOT  = 5'b00100,
      ST_SHIFT = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      slot_ok;

   // The held bin can move only when the result register has room.
   assign slot_ok = status.out_free | ~status.held_valid;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.group_done) begin
               state_in = ST_ROOT;
            end else if (status.last) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (slot_ok) begin
               cmd.shift = 1'b1;
               state_in  = status.last ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (slot_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/histogram_rebin_edge_trim.sv -----
// Top level of the histogram rebinning block with quadrature errors and
// edge trimming. Depends on hret_pkg, hret_if, hret_ctrl and hret_datapath.
//
//   channel   direction  word
//   req_bin   in         one fine bin: content, error, edges, last flag
//   rsp_bin   out        one coarse bin: content, error, edges, last flag
//   csr_wr    in         group size, always ready
//
// A fine bin that does not finish a group is accepted and then added.
// One that finishes a group is accepted, added, passes through the 19 square root
// steps in the bit-serial root unit and its done flag, and then hands over
// the held bin; a last bin adds the final flush.
// Reset is synchronous and needs no clearing pass; the group size returns
// to 5. While the result register is full and not taken, the block waits.
module histogram_rebin_edge_trim #(
   parameter int MAX_GROUP = 64
) (
   input  logic        clock,
   input  logic        reset,
   hret_req_if.sink    req_bin,
   hret_rsp_if.source  rsp_bin,
   hret_csr_if.sink    csr_wr
);

   hret_pkg::cmd_type    cmd;
   hret_pkg::status_type status;
   logic                 req_ready;

   // The register is always writable.
   assign csr_wr.ready  = 1'b1;
   assign req_bin.ready = req_ready;

   hret_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bin.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hret_datapath #(
      .MAX_GROUP (MAX_GROUP)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_wr.valid),
      .csr_data        (csr_wr.data),
      .fine_content    (req_bin.fine_content),
      .fine_error      (req_bin.fine_error),
      .fine_low_edge   (req_bin.fine_low_edge),
      .fine_up_edge    (req_bin.fine_up_edge),
      .fine_last       (req_bin.fine_last),
      .rsp_ready       (rsp_bin.ready),
      .rsp_valid       (rsp_bin.valid),
      .coarse_content  (rsp_bin.coarse_content),
      .coarse_error    (rsp_bin.coarse_error),
      .coarse_low_edge (rsp_bin.coarse_low_edge),
      .coarse_up_edge  (rsp_bin.coarse_up_edge),
      .coarse_last     (rsp_bin.coarse_last)
   );

endmodule
